FILE: hw/rtl/tscc_pkg.sv
`timescale 1ns / 1ps

package tscc_pkg;

  localparam int PID_W   = 13;
  localparam int CC_W    = 4;
  localparam int HDR_W   = 32;
  localparam int RES_W   = 32;

  localparam logic [7:0]       SYNC_BYTE = 8'h47;
  localparam logic [PID_W-1:0] PID_FIRST = 13'h0010;
  localparam logic [PID_W-1:0] PID_LAST  = 13'h1ffe;
  localparam logic [PID_W-1:0] PID_NULL  = 13'h1fff;

  localparam logic FUNC_PACKET = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [CC_W-1:0] cc;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [PID_W-1:0] pid;
    entry_t           entry;
  } tbl_upd_t;

  // one classified word as it leaves the input register
  typedef struct packed {
    logic en;
    logic tick;
    logic good;
    logic bad;
    logic cc_err;
    logic scr;
    logic signal;
  } event_t;

  typedef struct packed {
    logic             sec_err;
    logic             sec_ua;
    logic [RES_W-1:0] packet_count;
    logic [RES_W-1:0] cc_error_count;
    logic [RES_W-1:0] bad_sync_count;
    logic [RES_W-1:0] scrambled_count;
    logic [RES_W-1:0] errored_seconds;
    logic [RES_W-1:0] unavailable_seconds;
    logic [RES_W-1:0] bad_seconds;
  } report_t;

endpackage

FILE: hw/rtl/tscc_in_if.sv
`timescale 1ns / 1ps

interface tscc_in_if;
  import tscc_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [HDR_W-1:0] header;

  modport source (output valid, func, header, input ready);
  modport sink (input valid, func, header, output ready);
endinterface

FILE: hw/rtl/tscc_out_if.sv
`timescale 1ns / 1ps

interface tscc_out_if;
  import tscc_pkg::*;

  logic             valid;
  logic             ready;
  logic             cc_error;
  logic             bad_sync;
  logic             scrambled;
  logic             second_errored;
  logic             second_unavailable;
  logic [RES_W-1:0] packet_count;
  logic [RES_W-1:0] cc_error_count;
  logic [RES_W-1:0] bad_sync_count;
  logic [RES_W-1:0] scrambled_count;
  logic [RES_W-1:0] errored_seconds;
  logic [RES_W-1:0] unavailable_seconds;
  logic [RES_W-1:0] bad_seconds;

  modport source (
    output valid, cc_error, bad_sync, scrambled, second_errored, second_unavailable,
           packet_count, cc_error_count, bad_sync_count, scrambled_count,
           errored_seconds, unavailable_seconds, bad_seconds,
    input  ready
  );
  modport sink (
    input  valid, cc_error, bad_sync, scrambled, second_errored, second_unavailable,
           packet_count, cc_error_count, bad_sync_count, scrambled_count,
           errored_seconds, unavailable_seconds, bad_seconds,
    output ready
  );
endinterface

FILE: hw/rtl/tscc_pid_table.sv
`timescale 1ns / 1ps

module tscc_pid_table
  import tscc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [PID_W-1:0] rd_pid,
  input  tbl_upd_t         upd,
  output entry_t           entry,
  output logic             busy
);

  localparam int DEPTH = 2 ** PID_W;

  entry_t           mem [DEPTH];
  entry_t           rd_data;
  logic [PID_W-1:0] rd_pid_q;
  logic             clearing;
  logic [PID_W-1:0] clr_addr;
  logic             byp_valid;
  logic [PID_W-1:0] byp_pid;
  entry_t           byp_entry;

  // one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + PID_W'(1);
      if (clr_addr == PID_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (upd.en) begin
      mem[upd.pid] <= upd.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= mem[rd_pid];
      rd_pid_q <= rd_pid;
    end
  end

  // last write holds the current contents of its pid; covers read-before-write
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (upd.en) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      byp_pid   <= upd.pid;
      byp_entry <= upd.entry;
    end
  end

  assign entry = (byp_valid && byp_pid == rd_pid_q) ? byp_entry : rd_data;
  assign busy  = clearing;

endmodule

FILE: hw/rtl/tscc_stats.sv
`timescale 1ns / 1ps

module tscc_stats
  import tscc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  event_t  ev,
  output report_t rep
);

  logic                   error_seen, error_seen_next;
  logic                   signal_seen, signal_seen_next;
  logic [COUNT_WIDTH-1:0] good_packets, good_packets_next;
  logic [COUNT_WIDTH-1:0] cc_errors, cc_errors_next;
  logic [COUNT_WIDTH-1:0] sync_errors, sync_errors_next;
  logic [COUNT_WIDTH-1:0] scr_packets, scr_packets_next;
  logic [COUNT_WIDTH-1:0] errored_secs, errored_secs_next;
  logic [COUNT_WIDTH-1:0] ua_secs, ua_secs_next;
  logic [COUNT_WIDTH-1:0] bad_secs, bad_secs_next;
  logic                   sec_err;
  logic                   sec_ua;

  localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

  always_comb begin
    sec_err = ev.tick && error_seen;
    sec_ua  = ev.tick && !signal_seen;

    good_packets_next = ev.good   ? good_packets + ONE : good_packets;
    cc_errors_next    = ev.cc_err ? cc_errors + ONE    : cc_errors;
    sync_errors_next  = ev.bad    ? sync_errors + ONE  : sync_errors;
    scr_packets_next  = ev.scr    ? scr_packets + ONE  : scr_packets;
    errored_secs_next = sec_err   ? errored_secs + ONE : errored_secs;
    ua_secs_next      = sec_ua    ? ua_secs + ONE      : ua_secs;
    bad_secs_next     = (sec_err || sec_ua) ? bad_secs + ONE : bad_secs;

    if (ev.tick) begin
      error_seen_next  = 1'b0;
      signal_seen_next = 1'b0;
    end else begin
      error_seen_next  = error_seen || ev.bad || ev.cc_err;
      signal_seen_next = signal_seen || ev.signal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen   <= 1'b0;
      signal_seen  <= 1'b0;
      good_packets <= '0;
      cc_errors    <= '0;
      sync_errors  <= '0;
      scr_packets  <= '0;
      errored_secs <= '0;
      ua_secs      <= '0;
      bad_secs     <= '0;
    end else if (ev.en) begin
      error_seen   <= error_seen_next;
      signal_seen  <= signal_seen_next;
      good_packets <= good_packets_next;
      cc_errors    <= cc_errors_next;
      sync_errors  <= sync_errors_next;
      scr_packets  <= scr_packets_next;
      errored_secs <= errored_secs_next;
      ua_secs      <= ua_secs_next;
      bad_secs     <= bad_secs_next;
    end
  end

  always_comb begin
    rep.sec_err             = sec_err;
    rep.sec_ua              = sec_ua;
    rep.packet_count        = RES_W'(good_packets_next);
    rep.cc_error_count      = RES_W'(cc_errors_next);
    rep.bad_sync_count      = RES_W'(sync_errors_next);
    rep.scrambled_count     = RES_W'(scr_packets_next);
    rep.errored_seconds     = RES_W'(errored_secs_next);
    rep.unavailable_seconds = RES_W'(ua_secs_next);
    rep.bad_seconds         = RES_W'(bad_secs_next);
  end

endmodule

FILE: hw/rtl/ts_continuity_checker.sv
`timescale 1ns / 1ps

// transport stream continuity checker
// item channel: one word per packet header (func = 0, header = bytes 0..3, byte 0
// in bits 31..24) or per one-second tick (func = 1, header ignored)
// result channel: exactly one word per item, in order, carrying the per-packet
// flags, the per-second flags on a tick and all running counters after the update
// an accepted word is held in the input register, and its result in the result word
// throughput: one item per cycle while not stalled; the per-pid counter table is a
// single-port read / single write memory with a one-deep write bypass for back-to-back
// pids; reset: counters and second flags clear at once; the 8192-entry pid table is
// then cleared one entry per cycle, so item ready stays low until it is cleared
// stall: when the result word is not taken the input register holds its word and
// ready drops; no word is lost or repeated
// counters are COUNT_WIDTH bits wide and wrap; the result fields show the low 32 bits

module ts_continuity_checker
  import tscc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  tscc_in_if.sink    item,
  tscc_out_if.source result
);

  logic             s1_valid;
  logic             s1_func;
  logic [HDR_W-1:0] s1_header;
  logic             advance;
  logic             accept;
  logic             busy;
  entry_t           entry;
  tbl_upd_t         upd;
  event_t           ev;
  report_t          rep;

  logic [PID_W-1:0] pid;
  logic [CC_W-1:0]  cc;
  logic [CC_W-1:0]  cc_expect;
  logic             payload;
  logic             pid_checked;

  assign advance    = !result.valid || result.ready;
  assign item.ready = !busy && (!s1_valid || advance);
  assign accept     = item.valid && item.ready;

  tscc_pid_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_pid (item.header[PID_W+7:8]),
    .upd    (upd),
    .entry  (entry),
    .busy   (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func   <= item.func;
      s1_header <= item.header;
    end
  end

  always_comb begin
    pid         = s1_header[PID_W+7:8];
    cc          = s1_header[CC_W-1:0];
    payload     = s1_header[4];
    cc_expect   = entry.cc + CC_W'(1);
    pid_checked = (pid >= PID_FIRST) && (pid <= PID_LAST);

    ev.en     = s1_valid && advance;
    ev.tick   = s1_func == FUNC_TICK;
    ev.good   = (s1_func == FUNC_PACKET) && (s1_header[31:24] == SYNC_BYTE);
    ev.bad    = (s1_func == FUNC_PACKET) && (s1_header[31:24] != SYNC_BYTE);
    ev.cc_err = ev.good && pid_checked && entry.valid && payload && (cc_expect != cc);
    ev.scr    = ev.good && (s1_header[7:6] != 2'b00);
    ev.signal = ev.good && payload && (pid != PID_NULL);

    upd.en          = ev.en && ev.good;
    upd.pid         = pid;
    upd.entry.valid = 1'b1;
    upd.entry.cc    = cc;
  end

  tscc_stats #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_stats (
    .clk (clk),
    .rst (rst),
    .ev  (ev),
    .rep (rep)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.en) begin
      result.cc_error            <= ev.cc_err;
      result.bad_sync            <= ev.bad;
      result.scrambled           <= ev.scr;
      result.second_errored      <= rep.sec_err;
      result.second_unavailable  <= rep.sec_ua;
      result.packet_count        <= rep.packet_count;
      result.cc_error_count      <= rep.cc_error_count;
      result.bad_sync_count      <= rep.bad_sync_count;
      result.scrambled_count     <= rep.scrambled_count;
      result.errored_seconds     <= rep.errored_seconds;
      result.unavailable_seconds <= rep.unavailable_seconds;
      result.bad_seconds         <= rep.bad_seconds;
    end
  end

endmodule
